### sv/assert_macros.svh
// Assertion macros for the modules that carry concurrent checks.
// Each macro expects signals named clock and reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition in one cycle implies a consequence in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/pctc_pkg.sv
// Package for the preset countdown timer controller.
// Holds widths, event and button codes, register indexes and the status struct.
package pctc_pkg;

   localparam int NUM_PRESETS = 4;
   localparam int SEL_W       = $clog2(NUM_PRESETS);
   localparam int INDEX_W     = 2;
   localparam int PRESET_W    = 11;
   localparam int IDLE_W      = 16;
   localparam int DIGIT_W     = 4;
   localparam int BUTTON_W    = 3;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 32;

   typedef enum logic [1:0] {
      KIND_TICK,
      KIND_IDLE,
      KIND_PRESS,
      KIND_REPEAT
   } kind_type;

   localparam logic [BUTTON_W-1:0] BTN_GRIND = 3'd0;
   localparam logic [BUTTON_W-1:0] BTN_LEFT  = 3'd1;
   localparam logic [BUTTON_W-1:0] BTN_RIGHT = 3'd2;
   localparam logic [BUTTON_W-1:0] BTN_UP    = 3'd3;
   localparam logic [BUTTON_W-1:0] BTN_DOWN  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_PRESET_LIMIT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLEEP_LIMIT  = 1'b1;

   localparam logic [PRESET_W-1:0] PRESET_LIMIT_RESET = 11'd960;
   localparam logic [IDLE_W-1:0]   SLEEP_LIMIT_RESET  = 16'd1000;

   localparam logic [PRESET_W-1:0] PRESET_STEP = 11'd4;

   typedef struct packed {
      logic                relay_on;
      logic                asleep;
      logic [INDEX_W-1:0]  preset_index;
      logic [PRESET_W-1:0] remaining;
   } status_type;

endpackage

### sv/pctc_ctrl.sv
// Controller state and first result stage of the countdown timer.
// Applies one event per request to the presets, selection, countdown, grind and sleep state.
// Depends on pctc_pkg.
module pctc_ctrl
   import pctc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  csr_tvalid,
   output logic                  csr_tready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  st_valid,
   input  logic                  st_ready,
   output status_type            st_status
);

   logic [PRESET_W-1:0] preset_ff [NUM_PRESETS];
   logic [PRESET_W-1:0] preset_in [NUM_PRESETS];
   logic [SEL_W-1:0]    sel_ff, sel_in;
   logic [PRESET_W-1:0] countdown_ff, countdown_in;
   logic                grind_ff, grind_in;
   logic                sleep_ff, sleep_in;
   logic [IDLE_W-1:0]   idle_ff, idle_in;
   logic [PRESET_W-1:0] preset_limit_ff;
   logic [IDLE_W-1:0]   sleep_limit_ff;
   logic                st_valid_ff;
   status_type          status_ff, status_in;

   kind_type            kind;
   logic [BUTTON_W-1:0] button;
   logic                req_accept;
   logic                take_button;
   logic                awake_press;
   logic [PRESET_W-1:0] cur_preset;
   logic [PRESET_W:0]   up_sum;
   logic [PRESET_W-1:0] up_val, down_val;
   logic [IDLE_W-1:0]   idle_inc;

   assign kind       = kind_type'(req_tdata[1:0]);
   assign button     = req_tdata[4:2];
   assign req_tready = !st_valid_ff || st_ready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_tready = 1'b1;

   always_comb begin
      take_button = 1'b0;
      case (kind)
         KIND_PRESS:  take_button = !grind_ff;
         KIND_REPEAT: take_button = !grind_ff && (button inside {BTN_UP, BTN_DOWN});
         default:     take_button = 1'b0;
      endcase
      awake_press = take_button && !sleep_ff;
      sel_in = sel_ff;
      if (awake_press) begin
         case (button)
            BTN_LEFT: begin
               sel_in = (sel_ff == '0) ? SEL_W'(NUM_PRESETS - 1) : sel_ff - 1'b1;
            end
            BTN_RIGHT: begin
               sel_in = (sel_ff == SEL_W'(NUM_PRESETS - 1)) ? '0 : sel_ff + 1'b1;
            end
            default: sel_in = sel_ff;
         endcase
      end
   end

   assign cur_preset = preset_ff[sel_in];
   assign up_sum     = {1'b0, cur_preset} + {1'b0, PRESET_STEP};
   assign up_val     = (up_sum > {1'b0, preset_limit_ff}) ? preset_limit_ff
                                                          : up_sum[PRESET_W-1:0];
   assign down_val   = (cur_preset < PRESET_STEP) ? '0 : cur_preset - PRESET_STEP;
   assign idle_inc   = idle_ff + 1'b1;

   always_comb begin
      preset_in    = preset_ff;
      countdown_in = countdown_ff;
      grind_in     = grind_ff;
      sleep_in     = sleep_ff;
      idle_in      = idle_ff;
      case (kind)
         KIND_TICK: begin
            if (grind_ff) begin
               if (countdown_ff == '0) begin
                  grind_in     = 1'b0;
                  countdown_in = cur_preset;
               end else begin
                  countdown_in = countdown_ff - 1'b1;
               end
            end
         end
         KIND_IDLE: begin
            idle_in = idle_inc;
            if (idle_inc > sleep_limit_ff) begin
               idle_in  = '0;
               sleep_in = 1'b1;
            end
         end
         default: ;
      endcase
      if (take_button) begin
         idle_in = '0;
         if (sleep_ff) begin
            sleep_in = 1'b0;
         end else begin
            case (button)
               BTN_GRIND: grind_in = 1'b1;
               BTN_UP: begin
                  preset_in[sel_in] = up_val;
                  countdown_in      = up_val;
               end
               BTN_DOWN: begin
                  preset_in[sel_in] = down_val;
                  countdown_in      = down_val;
               end
               default: countdown_in = cur_preset;
            endcase
         end
      end
      status_in.relay_on     = grind_in;
      status_in.asleep       = sleep_in;
      status_in.preset_index = INDEX_W'(sel_in);
      status_in.remaining    = countdown_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PRESETS; i++) begin
            preset_ff[i] <= '0;
         end
         sel_ff       <= '0;
         countdown_ff <= '0;
         grind_ff     <= 1'b0;
         sleep_ff     <= 1'b0;
         idle_ff      <= '0;
      end else if (req_accept) begin
         preset_ff    <= preset_in;
         sel_ff       <= sel_in;
         countdown_ff <= countdown_in;
         grind_ff     <= grind_in;
         sleep_ff     <= sleep_in;
         idle_ff      <= idle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         preset_limit_ff <= PRESET_LIMIT_RESET;
         sleep_limit_ff  <= SLEEP_LIMIT_RESET;
      end else if (csr_tvalid && csr_tready) begin
         case (csr_index)
            CSR_PRESET_LIMIT: preset_limit_ff <= csr_wdata[PRESET_W-1:0];
            CSR_SLEEP_LIMIT:  sleep_limit_ff  <= csr_wdata[IDLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
      end else if (req_tready) begin
         st_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         status_ff <= status_in;
      end
   end

   assign st_valid  = st_valid_ff;
   assign st_status = status_ff;

endmodule

### sv/pctc_digits.sv
// Output stage of the countdown timer: decimal digits and the result register.
// Converts the remaining count in sixteenths of a second to four digits.
// Depends on pctc_pkg.
module pctc_digits
   import pctc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  st_valid,
   output logic                  st_ready,
   input  status_type            st_status,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   function automatic logic [DIGIT_W-1:0] hundredths_of(input logic [3:0] frac);
      logic [DIGIT_W-1:0] digit;
      case (frac)
         4'd0, 4'd8:   digit = 4'd0;
         4'd1, 4'd9:   digit = 4'd6;
         4'd2, 4'd10:  digit = 4'd2;
         4'd3, 4'd11:  digit = 4'd8;
         4'd4, 4'd12:  digit = 4'd5;
         4'd5, 4'd13:  digit = 4'd1;
         4'd6, 4'd14:  digit = 4'd7;
         4'd7, 4'd15:  digit = 4'd3;
         default:      digit = 4'd0;
      endcase
      return digit;
   endfunction

   logic                  out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;

   logic [6:0]            secs;
   logic [3:0]            frac;
   logic [14:0]           secs_scaled;
   logic [3:0]            secs_div10;
   logic [6:0]            secs_tens;
   logic [7:0]            frac_scaled;
   logic [DIGIT_W-1:0]    tens_digit, ones_digit, tenths_digit, hundredths_digit;

   assign secs        = st_status.remaining[PRESET_W-1:4];
   assign frac        = st_status.remaining[3:0];
   assign secs_scaled = {8'd0, secs} * 15'd205;
   assign secs_div10  = secs_scaled[14:11];
   assign secs_tens   = {3'd0, secs_div10} * 7'd10;
   assign ones_digit  = DIGIT_W'(secs - secs_tens);
   assign tens_digit  = (secs_div10 >= 4'd10) ? secs_div10 - 4'd10 : secs_div10;
   assign frac_scaled = {4'd0, frac} * 8'd10;
   assign tenths_digit     = frac_scaled[7:4];
   assign hundredths_digit = hundredths_of(frac);

   assign out_data_in = {1'b0, hundredths_digit, tenths_digit, ones_digit, tens_digit,
                         st_status.remaining, st_status.preset_index,
                         st_status.asleep, st_status.relay_on};

   assign st_ready = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (st_ready) begin
         out_valid_ff <= st_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (st_valid && st_ready) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

### sv/preset_countdown_timer_controller_top.sv
// Preset countdown timer controller, top level.
// A result passes through the status register in pctc_ctrl, then the output register in pctc_digits.
// Throughput: one request per cycle while rsp_tready does not hold the output back.
// Synchronous active-high reset clears the presets, selection, countdown,
// grind and sleep state, and loads the two limit registers with their defaults.
`include "assert_macros.svh"

module preset_countdown_timer_controller_top
   import pctc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // kind[1:0], button[4:2], zero[7:5]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // relay_on[0], asleep[1], preset_index[3:2], remaining[14:4], tens_digit[18:15],
   // ones_digit[22:19], tenths_digit[26:23], hundredths_digit[30:27], zero[31]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_tvalid,
   output logic                  csr_tready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic       st_valid;
   logic       st_ready;
   status_type st_status;

   pctc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .st_valid   (st_valid),
      .st_ready   (st_ready),
      .st_status  (st_status)
   );

   pctc_digits u_digits (
      .clock      (clock),
      .reset      (reset),
      .st_valid   (st_valid),
      .st_ready   (st_ready),
      .st_status  (st_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   `ASSERT_NEXT(a_req_reaches_stage, req_tvalid && req_tready, st_valid, "accepted request lost")
   `ASSERT_NEXT(a_stage_reaches_out, st_valid && st_ready, rsp_tvalid && (rsp_tdata[14:4] == $past(st_status.remaining)), "stage result not registered")
   `ASSERT_ALWAYS(a_digits_decimal, !rsp_tvalid || ((rsp_tdata[18:15] <= 4'd9) && (rsp_tdata[22:19] <= 4'd9) && (rsp_tdata[26:23] <= 4'd9) && (rsp_tdata[30:27] <= 4'd9)), "digit out of range")

endmodule
